// ===== rtl/doq_pkg.sv =====
package doq_pkg;

    // Queue geometry and field widths.
    localparam int DEPTH      = 64;
    localparam int KEY_BITS   = 16;
    localparam int ID_BITS    = 8;
    localparam int PTR_BITS   = $clog2(DEPTH);
    localparam int CNT_BITS   = $clog2(DEPTH + 1);
    localparam int ENTRY_BITS = KEY_BITS + ID_BITS;
    localparam int MODE_BITS  = 2;
    localparam int WANT_BITS  = 7;
    localparam int SLOT_BITS  = 6;
    localparam int OCC_BITS   = 7;

    // Operation codes carried by the mode field.
    localparam logic [MODE_BITS-1:0] MODE_RESERVE = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_POP     = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_DEPART  = 2'd2;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_INSERT,
        S_POP_RD,
        S_POP_OUT,
        S_DEP_RD,
        S_DEP_OUT,
        S_FLAG
    } state_t;

    // Kind of result loaded into the output register.
    typedef enum logic [1:0] {
        RES_INSERT,
        RES_POP,
        RES_DEPART,
        RES_FLAG
    } res_kind_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      load_item;
        logic      prep;
        logic      rd_prev;
        logic      rd_cur;
        logic      shift_wr;
        logic      ins_wr;
        logic      pop_commit;
        logic      idx_inc;
        logic      emit;
        res_kind_t res;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [MODE_BITS-1:0] mode;
        logic                 full;
        logic                 empty;
        logic                 fast_append;
        logic                 depart_none;
        logic                 idx_zero;
        logic                 key_le;
        logic                 dep_last;
        logic                 out_free;
    } dp_stat_t;

endpackage

// ===== rtl/doq_ifs.sv =====
// Request channel: one queue operation.
interface doq_req_if;
    logic                           valid;
    logic                           ready;
    logic [doq_pkg::MODE_BITS-1:0]  mode;
    logic [doq_pkg::ID_BITS-1:0]    agent_id;
    logic [doq_pkg::KEY_BITS-1:0]   leave_key;
    logic [doq_pkg::WANT_BITS-1:0]  depart_count;

    modport source (output valid, mode, agent_id, leave_key, depart_count, input ready);
    modport sink (input valid, mode, agent_id, leave_key, depart_count, output ready);
endinterface

// Result channel: one result of an operation.
interface doq_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [doq_pkg::ID_BITS-1:0]    out_agent;
    logic [doq_pkg::SLOT_BITS-1:0]  out_slot;
    logic [doq_pkg::OCC_BITS-1:0]   occupancy;
    logic                           agent_valid;
    logic                           error;
    logic                           last;

    modport source (output valid, out_agent, out_slot, occupancy, agent_valid, error, last,
                    input ready);
    modport sink (input valid, out_agent, out_slot, occupancy, agent_valid, error, last,
                  output ready);
endinterface

// ===== rtl/doq_ram.sv =====
module doq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port and one registered read port; read data holds when idle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/doq_ctrl.sv =====
module doq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  doq_pkg::dp_stat_t stat,
    output doq_pkg::dp_cmd_t  cmd
);

    import doq_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (stat.mode)
                    MODE_RESERVE:
                    begin
                        if (stat.full)
                        begin
                            state_next = S_FLAG;
                        end
                        else if (stat.fast_append)
                        begin
                            state_next = S_INSERT;
                        end
                        else
                        begin
                            state_next = S_SCAN_RD;
                        end
                    end
                    MODE_POP:
                    begin
                        state_next = stat.empty ? S_FLAG : S_POP_RD;
                    end
                    MODE_DEPART:
                    begin
                        state_next = stat.depart_none ? S_FLAG : S_DEP_RD;
                    end
                    default:
                    begin
                        state_next = S_FLAG;
                    end
                endcase
            end
            S_SCAN_RD:
            begin
                state_next = stat.idx_zero ? S_INSERT : S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                state_next = stat.key_le ? S_INSERT : S_SCAN_RD;
            end
            S_INSERT, S_POP_OUT, S_FLAG:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_POP_RD:
            begin
                state_next = S_POP_OUT;
            end
            S_DEP_RD:
            begin
                state_next = S_DEP_OUT;
            end
            S_DEP_OUT:
            begin
                if (stat.out_free)
                begin
                    state_next = stat.dep_last ? S_IDLE : S_DEP_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output logic: handshake and datapath commands.
    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        cmd.res  = RES_FLAG;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_item = in_valid;
            end
            S_DECODE:
            begin
                cmd.prep = 1'b1;
            end
            S_SCAN_RD:
            begin
                cmd.rd_prev = !stat.idx_zero;
            end
            S_SCAN_CMP:
            begin
                cmd.shift_wr = !stat.key_le;
            end
            S_INSERT:
            begin
                cmd.ins_wr = stat.out_free;
                cmd.emit   = stat.out_free;
                cmd.res    = RES_INSERT;
            end
            S_POP_RD, S_DEP_RD:
            begin
                cmd.rd_cur = 1'b1;
            end
            S_POP_OUT:
            begin
                cmd.pop_commit = stat.out_free;
                cmd.emit       = stat.out_free;
                cmd.res        = RES_POP;
            end
            S_DEP_OUT:
            begin
                cmd.idx_inc = stat.out_free;
                cmd.emit    = stat.out_free;
                cmd.res     = RES_DEPART;
            end
            S_FLAG:
            begin
                cmd.emit = stat.out_free;
                cmd.res  = RES_FLAG;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/doq_dp.sv =====
module doq_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [doq_pkg::MODE_BITS-1:0]  mode,
    input  logic [doq_pkg::ID_BITS-1:0]    agent_id,
    input  logic [doq_pkg::KEY_BITS-1:0]   leave_key,
    input  logic [doq_pkg::WANT_BITS-1:0]  depart_count,
    input  doq_pkg::dp_cmd_t               cmd,
    output doq_pkg::dp_stat_t              stat,
    doq_rsp_if.source                      rsp
);

    import doq_pkg::*;

    // Captured request.
    logic [MODE_BITS-1:0] mode_reg;
    logic [ID_BITS-1:0]   agent_reg;
    logic [KEY_BITS-1:0]  key_reg;
    logic [WANT_BITS-1:0] want_reg;

    // Queue bookkeeping: occupancy, head of the ring, logical index, run length.
    logic [CNT_BITS-1:0]  count_reg;
    logic [CNT_BITS-1:0]  count_next;
    logic [PTR_BITS-1:0]  head_reg;
    logic [CNT_BITS-1:0]  idx_reg;
    logic [CNT_BITS-1:0]  n_reg;
    logic [CNT_BITS-1:0]  n_calc;

    // Result register.
    logic                 out_valid_reg;
    logic [ID_BITS-1:0]   out_agent_reg;
    logic [SLOT_BITS-1:0] out_slot_reg;
    logic [OCC_BITS-1:0]  occ_reg;
    logic                 agent_valid_reg;
    logic                 error_reg;
    logic                 last_reg;

    // Entry store access.
    logic                  wr_en;
    logic [PTR_BITS-1:0]   wr_addr;
    logic [ENTRY_BITS-1:0] wr_data;
    logic                  rd_en;
    logic [PTR_BITS-1:0]   rd_addr;
    logic [ENTRY_BITS-1:0] rd_data;
    logic [KEY_BITS-1:0]   rd_key;
    logic [ID_BITS-1:0]    rd_agent;
    logic [CNT_BITS-1:0]   rd_idx;
    logic                  out_free;
    logic                  dep_last;

    // Map a logical queue position onto a physical slot of the ring.
    function automatic logic [PTR_BITS-1:0] phys(input logic [PTR_BITS-1:0] head,
                                                 input logic [CNT_BITS-1:0] pos);
        logic [CNT_BITS:0] sum;
        sum = {{(CNT_BITS + 1 - PTR_BITS){1'b0}}, head} + {1'b0, pos};
        if (sum >= (CNT_BITS + 1)'(DEPTH))
        begin
            sum = sum - (CNT_BITS + 1)'(DEPTH);
        end
        return sum[PTR_BITS-1:0];
    endfunction

    assign rd_key   = rd_data[ENTRY_BITS-1:ID_BITS];
    assign rd_agent = rd_data[ID_BITS-1:0];
    assign out_free = !out_valid_reg || rsp.ready;
    assign dep_last = ((CNT_BITS + 1)'(idx_reg) + 1'b1) == (CNT_BITS + 1)'(n_reg);

    // Depart run length, clamped to the occupancy.
    assign n_calc = (32'(want_reg) > 32'(count_reg)) ? count_reg : CNT_BITS'(want_reg);

    // Status toward the controller.
    always_comb
    begin
        stat.mode        = mode_reg;
        stat.full        = count_reg >= CNT_BITS'(DEPTH);
        stat.empty       = count_reg == '0;
        stat.fast_append = (count_reg == '0) || (key_reg == '1);
        stat.depart_none = n_calc == '0;
        stat.idx_zero    = idx_reg == '0;
        stat.key_le      = rd_key <= key_reg;
        stat.dep_last    = dep_last;
        stat.out_free    = out_free;
    end

    // Store ports: reads walk back from the gap or forward from the head.
    always_comb
    begin
        rd_en   = cmd.rd_prev || cmd.rd_cur;
        rd_idx  = cmd.rd_prev ? (idx_reg - 1'b1) : idx_reg;
        rd_addr = phys(head_reg, rd_idx);
        wr_en   = cmd.shift_wr || cmd.ins_wr;
        wr_addr = phys(head_reg, idx_reg);
        wr_data = cmd.ins_wr ? {key_reg, agent_reg} : rd_data;
    end

    doq_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Occupancy after this cycle's commit.
    always_comb
    begin
        count_next = count_reg;
        if (cmd.ins_wr)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.pop_commit)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Control state: occupancy, ring head and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            head_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.pop_commit)
            begin
                head_reg <= phys(head_reg, CNT_BITS'(1));
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Request capture and walk index.
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            mode_reg  <= mode;
            agent_reg <= agent_id;
            key_reg   <= leave_key;
            want_reg  <= depart_count;
        end
        if (cmd.prep)
        begin
            idx_reg <= (mode_reg == MODE_RESERVE) ? count_reg : '0;
            n_reg   <= n_calc;
        end
        else if (cmd.shift_wr)
        begin
            idx_reg <= idx_reg - 1'b1;
        end
        else if (cmd.idx_inc)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            occ_reg <= OCC_BITS'(count_next);
            case (cmd.res)
                RES_INSERT:
                begin
                    out_agent_reg   <= agent_reg;
                    out_slot_reg    <= SLOT_BITS'(idx_reg);
                    agent_valid_reg <= 1'b1;
                    error_reg       <= 1'b0;
                    last_reg        <= 1'b1;
                end
                RES_POP:
                begin
                    out_agent_reg   <= rd_agent;
                    out_slot_reg    <= '0;
                    agent_valid_reg <= 1'b1;
                    error_reg       <= 1'b0;
                    last_reg        <= 1'b1;
                end
                RES_DEPART:
                begin
                    out_agent_reg   <= rd_agent;
                    out_slot_reg    <= SLOT_BITS'(idx_reg);
                    agent_valid_reg <= 1'b1;
                    error_reg       <= 1'b0;
                    last_reg        <= dep_last;
                end
                default:
                begin
                    out_agent_reg   <= '0;
                    out_slot_reg    <= '0;
                    agent_valid_reg <= 1'b0;
                    error_reg       <= (mode_reg == MODE_RESERVE) || (mode_reg == MODE_POP);
                    last_reg        <= 1'b1;
                end
            endcase
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.out_agent   = out_agent_reg;
    assign rsp.out_slot    = out_slot_reg;
    assign rsp.occupancy   = occ_reg;
    assign rsp.agent_valid = agent_valid_reg;
    assign rsp.error       = error_reg;
    assign rsp.last        = last_reg;

`ifndef SYNTHESIS
    // A new result is never loaded over one that has not been taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || rsp.ready))
        else $error("result register overwritten");

    // An insert only commits while a slot is free.
    a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins_wr |-> (count_reg < CNT_BITS'(DEPTH)))
        else $error("insert into full queue");

    // A pop only commits while the queue holds an entry.
    a_pop_held: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop_commit |-> (count_reg != '0))
        else $error("pop from empty queue");

    // After an insert or pop commit the occupancy stays within the depth.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.ins_wr || cmd.pop_commit) |=> (count_reg <= CNT_BITS'(DEPTH)))
        else $error("occupancy out of range");
`endif

endmodule

// ===== rtl/departure_ordered_queue_top.sv =====
// Channel  Role    Payload
// req      sink    mode, agent_id, leave_key, depart_count
// rsp      source  out_agent, out_slot, occupancy, agent_valid, error, last
//
// One request at a time. Reserve appends at once if the queue is empty or the key is all
// ones, else walks back from the tail moving each entry with a larger key up one slot.
// Pop removes the head; depart lists up to depart_count entries from the head, one result per entry.
// Each moved or listed entry costs one registered read of the entry store.
// Reset clears occupancy, head and result valid; the entry store needs no clearing pass.
// A held result waits in the output register; the walk stalls only when a
// further result is due and the register is still full.
module departure_ordered_queue_top (
    input  logic    clk,
    input  logic    rst_n,
    doq_req_if.sink req,
    doq_rsp_if.source rsp
);

    import doq_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     in_ready;

    assign req.ready = in_ready;

    doq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    doq_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .mode         (req.mode),
        .agent_id     (req.agent_id),
        .leave_key    (req.leave_key),
        .depart_count (req.depart_count),
        .cmd          (cmd),
        .stat         (stat),
        .rsp          (rsp)
    );

endmodule
